// ===== src/pes_pkg.sv =====
// Package for the periodic event scheduler: codes, widths and shared types.
// No dependencies.
`default_nettype none
package pes_pkg;
    localparam int OBJ_W  = 32;
    localparam int TAG_W  = 33;
    localparam int PER_W  = 16;
    localparam int TIME_W = 32;

    localparam logic [1:0] MODE_REG  = 2'd0;
    localparam logic [1:0] MODE_UPD  = 2'd1;
    localparam logic [1:0] MODE_PROC = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] KIND_STATUS   = 2'd0;
    localparam logic [1:0] KIND_FIRED    = 2'd1;
    localparam logic [1:0] KIND_DEADLINE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOTFD = 2'd3;

    localparam logic [15:0] IDLE_RESET = 16'd1000;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item, start scan at 0
        logic scan_next;  // advance scan index (issues a memory read)
        logic div_start;  // start modulo of late by period
        logic write_new;  // append entry
        logic write_upd;  // rewrite period/due at found index
        logic write_due;  // write realigned due at scan index
        logic fold;       // fold current entry due into deadline
        logic emit;       // load output register
        logic [1:0] out_kind;
        logic [1:0] out_status;
        logic out_last;
    } pes_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;  // scan index reached entry count
        logic match;      // current entry key equals item key
        logic active;     // current entry period nonzero
        logic due_now;    // current entry due not after now
        logic div_busy;
        logic full;
        logic out_busy;   // output register holds an untaken result
    } pes_sts_t;
endpackage
`default_nettype wire

// ===== src/pes_datapath.sv =====
// Datapath: entry memories, scan index, serial modulo, deadline and output register.
// Depends on pes_pkg.
`default_nettype none
module pes_datapath #(
    parameter int ENTRIES = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pes_pkg::pes_cmd_t cmd,
    input  wire logic             hit,
    output pes_pkg::pes_sts_t     sts,
    input  wire logic [15:0]      max_idle_ms,
    input  wire logic [31:0]      obj_id,
    input  wire logic [15:0]      inst_id,
    input  wire logic [7:0]       event_kind,
    input  wire logic [7:0]       target_id,
    input  wire logic             target_is_queue,
    input  wire logic [15:0]      period_ms,
    input  wire logic signed [31:0] initial_due,
    input  wire logic signed [31:0] time_now,
    input  wire logic             out_stall,
    output logic                  valid,
    output logic [1:0]            kind,
    output logic [1:0]            status,
    output logic [31:0]           fired_obj,
    output logic [15:0]           fired_inst,
    output logic [7:0]            fired_event,
    output logic [7:0]            fired_target,
    output logic                  fired_to_queue,
    output logic signed [31:0]    deadline,
    output logic                  last
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [31:0] mem_obj [ENTRIES];
    logic [32:0] mem_tag [ENTRIES];
    logic [15:0] mem_per [ENTRIES];
    logic [31:0] mem_due [ENTRIES];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [31:0] rd_obj_reg;
    logic [32:0] rd_tag_reg;
    logic [15:0] rd_per_reg;
    logic [31:0] rd_due_reg;

    logic [31:0] k_obj_reg;
    logic [32:0] k_tag_reg;
    logic [15:0] k_per_reg;
    logic [31:0] k_due_reg;
    logic [31:0] now_reg;
    logic [31:0] next_reg;
    logic [IW-1:0] hit_idx_reg;

    // serial restoring modulo
    logic [31:0] div_q_reg;
    logic [16:0] div_r_reg;
    logic [5:0]  div_cnt_reg;
    logic        div_busy_reg;
    logic [16:0] div_shift;
    logic [16:0] div_sub;

    logic out_valid_reg;
    logic [1:0] kind_reg, status_reg;
    logic [31:0] fobj_reg;
    logic [32:0] ftag_reg;
    logic [31:0] dl_reg;
    logic last_reg;

    logic [31:0] new_due;
    logic [31:0] cand_due;
    logic [IW-1:0] wr_idx;

    assign new_due = now_reg + {16'd0, rd_per_reg} - {16'd0, div_r_reg[15:0]};
    assign cand_due = cmd.write_due ? new_due : rd_due_reg;
    assign wr_idx = count_reg[IW-1:0];
    assign div_shift = {div_r_reg[15:0], div_q_reg[31]};
    assign div_sub = div_shift - {1'b0, rd_per_reg};

    assign sts.scan_done = (idx_reg >= count_reg);
    assign sts.match = (rd_obj_reg == k_obj_reg) && (rd_tag_reg == k_tag_reg);
    assign sts.active = (rd_per_reg != 16'd0);
    assign sts.due_now = !($signed(now_reg) < $signed(rd_due_reg));
    assign sts.div_busy = div_busy_reg;
    assign sts.full = (count_reg >= CW'(ENTRIES));
    assign sts.out_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk)
    begin
        if (cmd.scan_next)
        begin
            rd_idx_reg <= idx_reg[IW-1:0];
            rd_obj_reg <= mem_obj[idx_reg[IW-1:0]];
            rd_tag_reg <= mem_tag[idx_reg[IW-1:0]];
            rd_per_reg <= mem_per[idx_reg[IW-1:0]];
            rd_due_reg <= mem_due[idx_reg[IW-1:0]];
        end
        if (cmd.write_new)
        begin
            mem_obj[wr_idx] <= k_obj_reg;
            mem_tag[wr_idx] <= k_tag_reg;
            mem_per[wr_idx] <= k_per_reg;
            mem_due[wr_idx] <= k_due_reg;
        end
        else if (cmd.write_upd)
        begin
            mem_per[hit_idx_reg] <= k_per_reg;
            mem_due[hit_idx_reg] <= k_due_reg;
        end
        else if (cmd.write_due)
        begin
            mem_due[rd_idx_reg] <= new_due;
        end
        if (cmd.load)
        begin
            k_obj_reg <= obj_id;
            k_tag_reg <= {inst_id, event_kind, target_id, target_is_queue};
            k_per_reg <= period_ms;
            k_due_reg <= initial_due;
            now_reg   <= time_now;
            next_reg  <= time_now + {16'd0, max_idle_ms};
        end
        else if (cmd.fold)
        begin
            if ($signed(cand_due) < $signed(next_reg))
                next_reg <= cand_due;
        end
        if (hit)
            hit_idx_reg <= rd_idx_reg;
        if (cmd.div_start)
        begin
            div_q_reg <= now_reg - rd_due_reg;
            div_r_reg <= 17'd0;
        end
        else if (div_busy_reg)
        begin
            div_q_reg <= {div_q_reg[30:0], 1'b0};
            div_r_reg <= div_sub[16] ? div_shift : div_sub;
        end
        if (cmd.emit)
        begin
            kind_reg   <= cmd.out_kind;
            status_reg <= cmd.out_status;
            fobj_reg   <= (cmd.out_kind == pes_pkg::KIND_FIRED) ? rd_obj_reg : 32'd0;
            ftag_reg   <= (cmd.out_kind == pes_pkg::KIND_FIRED) ? rd_tag_reg : 33'd0;
            dl_reg     <= (cmd.out_kind == pes_pkg::KIND_DEADLINE) ? next_reg : 32'd0;
            last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_new)
                count_reg <= count_reg + CW'(1);
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.scan_next)
                idx_reg <= idx_reg + CW'(1);
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 6'd0;
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd31)
                    div_busy_reg <= 1'b0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign valid          = out_valid_reg;
    assign kind           = kind_reg;
    assign status         = status_reg;
    assign fired_obj      = fobj_reg;
    assign fired_inst     = ftag_reg[32:17];
    assign fired_event    = ftag_reg[16:9];
    assign fired_target   = ftag_reg[8:1];
    assign fired_to_queue = ftag_reg[0];
    assign deadline       = dl_reg;
    assign last           = last_reg;
endmodule
`default_nettype wire

// ===== src/pes_ctrl.sv =====
// Controller state machine sequencing register, update and process items.
// Depends on pes_pkg.
`default_nettype none
module pes_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        mode,
    output logic                   in_stall,
    input  wire pes_pkg::pes_sts_t sts,
    output pes_pkg::pes_cmd_t      cmd,
    output logic                   hit_latch
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_ANS   = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PCHK  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIRE  = 4'd7;
    localparam logic [3:0] S_DL    = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] st_reg, st_next;
    logic found_reg, found_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        st_next    = st_reg;
        found_next = found_reg;
        cmd        = '0;
        hit_latch  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (mode != pes_pkg::MODE_NONE))
                begin
                    cmd.load   = 1'b1;
                    mode_next  = mode;
                    found_next = 1'b0;
                    state_next = (mode == pes_pkg::MODE_PROC) ? S_PRD : S_RD;
                end
            end
            S_RD:
            begin
                if (sts.scan_done)
                    state_next = S_ANS;
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.match)
                begin
                    found_next = 1'b1;
                    hit_latch  = 1'b1;
                    state_next = S_ANS;
                end
                else
                    state_next = S_RD;
            end
            S_ANS:
            begin
                if (!sts.out_busy)
                begin
                    if (mode_reg == pes_pkg::MODE_REG)
                    begin
                        if (found_reg)
                            st_next = pes_pkg::ST_DUP;
                        else if (sts.full)
                            st_next = pes_pkg::ST_FULL;
                        else
                        begin
                            st_next = pes_pkg::ST_OK;
                            cmd.write_new = 1'b1;
                        end
                    end
                    else if (found_reg)
                    begin
                        st_next = pes_pkg::ST_OK;
                        cmd.write_upd = 1'b1;
                    end
                    else
                        st_next = pes_pkg::ST_NOTFD;
                    cmd.emit       = 1'b1;
                    cmd.out_kind   = pes_pkg::KIND_STATUS;
                    cmd.out_status = st_next;
                    cmd.out_last   = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            S_PRD:
            begin
                if (sts.scan_done)
                    state_next = S_DL;
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (!sts.active)
                    state_next = S_PRD;
                else if (sts.due_now)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.fold = 1'b1;
                    state_next = S_PRD;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                    state_next = S_FIRE;
            end
            S_FIRE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.write_due = 1'b1;
                    cmd.fold      = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.out_kind  = pes_pkg::KIND_FIRED;
                    state_next    = S_PRD;
                end
            end
            S_DL:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    cmd.out_kind = pes_pkg::KIND_DEADLINE;
                    cmd.out_last = 1'b1;
                    state_next   = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= pes_pkg::MODE_REG;
            st_reg    <= pes_pkg::ST_OK;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            st_reg    <= st_next;
            found_reg <= found_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/periodic_event_scheduler_unit.sv =====
// Top level of the periodic event scheduler: APB register, controller, datapath.
// Depends on pes_pkg, pes_ctrl, pes_datapath.
//
//  channel   direction  handshake          payload
//  in        sink       in_valid/in_stall  mode .. time_now
//  out       source     valid/stall        kind .. last
//  apb       slave      psel/penable       max_idle_ms at 0x0
//
// Register and update items scan the stored entries until a match or the end.
// Process items scan every stored entry; each fired entry waits for the
// one-bit-a-cycle modulo unit, and the deadline result follows the scan.
// Reset empties the table and sets max_idle_ms to 1000.
// A stalled result holds the sequencer until it is taken.
`default_nettype none
module periodic_event_scheduler_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [1:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       mode,
    input  wire logic [31:0]      obj_id,
    input  wire logic [15:0]      inst_id,
    input  wire logic [7:0]       event_kind,
    input  wire logic [7:0]       target_id,
    input  wire logic             target_is_queue,
    input  wire logic [15:0]      period_ms,
    input  wire logic signed [31:0] initial_due,
    input  wire logic signed [31:0] time_now,
    output logic                  valid,
    input  wire logic             stall,
    output logic [1:0]            kind,
    output logic [1:0]            status,
    output logic [31:0]           fired_obj,
    output logic [15:0]           fired_inst,
    output logic [7:0]            fired_event,
    output logic [7:0]            fired_target,
    output logic                  fired_to_queue,
    output logic signed [31:0]    deadline,
    output logic                  last
);
    logic [15:0] idle_reg;
    pes_pkg::pes_cmd_t cmd, cmd_c;
    pes_pkg::pes_sts_t sts;
    logic hit_latch;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, idle_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_reg <= pes_pkg::IDLE_RESET;
        else if (psel && penable && pwrite && (paddr == 2'd0))
            idle_reg <= pwdata[15:0];
    end

    pes_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .mode(mode),
        .in_stall(in_stall), .sts(sts), .cmd(cmd_c), .hit_latch(hit_latch)
    );

    assign cmd = cmd_c;

    pes_datapath #(.ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .hit(hit_latch), .sts(sts),
        .max_idle_ms(idle_reg), .obj_id(obj_id), .inst_id(inst_id),
        .event_kind(event_kind), .target_id(target_id),
        .target_is_queue(target_is_queue), .period_ms(period_ms),
        .initial_due(initial_due), .time_now(time_now), .out_stall(stall),
        .valid(valid), .kind(kind), .status(status), .fired_obj(fired_obj),
        .fired_inst(fired_inst), .fired_event(fired_event),
        .fired_target(fired_target), .fired_to_queue(fired_to_queue),
        .deadline(deadline), .last(last)
    );
endmodule
`default_nettype wire

// ===== src/pes_checker.sv =====
// Port-level checker for the periodic event scheduler, bound to the top level.
// Depends on pes_pkg.
`default_nettype none
module pes_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        valid,
    input wire logic        stall,
    input wire logic [1:0]  kind,
    input wire logic [1:0]  status,
    input wire logic [31:0] fired_obj,
    input wire logic [31:0] deadline,
    input wire logic        last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && stall |=> valid && $stable(kind) && $stable(deadline))
        else $error("result changed while stalled");
    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind == pes_pkg::KIND_FIRED) |-> !last)
        else $error("fired event marked last");
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind == pes_pkg::KIND_STATUS) |-> last)
        else $error("status answer not last");
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind != pes_pkg::KIND_FIRED) |-> (fired_obj == 32'd0))
        else $error("object field not cleared");
    a_ok_kind: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (kind != pes_pkg::KIND_STATUS) |-> (status == pes_pkg::ST_OK))
        else $error("status nonzero on non-status result");
endmodule

bind periodic_event_scheduler_unit pes_checker u_pes_checker (
    .clk(clk), .rst_n(rst_n),
    .valid(valid), .stall(stall), .kind(kind), .status(status),
    .fired_obj(fired_obj), .deadline(deadline), .last(last)
);
`default_nettype wire
